[sv/hsort_pkg.sv]
// ----------------------------------------------------------------------------
// hsort_pkg
// shared constants and types of the heap sorter
// ----------------------------------------------------------------------------
package hsort_pkg;

  // default capacity and value width
  localparam int unsigned MAX_ITEMS_DEF  = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BUILD,
    ST_BUILD_GET,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_SWAP_RD,
    ST_SWAP_WR,
    ST_EMIT_RD,
    ST_EMIT_SHOW,
    ST_EMIT_WAIT
  } hsort_state_e;

endpackage

[sv/hsort_ram.sv]
// ----------------------------------------------------------------------------
// hsort_ram
// generic ram, one write port, two read ports, registered read data
// ----------------------------------------------------------------------------
module hsort_ram
  import hsort_pkg::*;
#(
  parameter int unsigned WIDTH = VALUE_BITS_DEF,
  parameter int unsigned DEPTH = MAX_ITEMS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

[sv/heap_sorter.sv]
// ----------------------------------------------------------------------------
// heap_sorter
// collects a set of signed values and streams them back in ascending order
// ----------------------------------------------------------------------------
// Values arrive one item per cycle on the slave side and are written into a
// single dual-read-port ram of MAX_ITEMS entries; an item with tlast set ends
// the set. Values beyond capacity are dropped and flagged on tuser of every
// result of that run. After the last item the input stalls while a
// sequencer heapsorts the ram in place: a bottom-up max-heap build, then
// root/end swaps with sift-down. Each sift level reads both children, then
// compares and writes back; each sift starts by reading its first value (the
// build node, or root and end for a swap). Results then leave one at a time,
// each read from ram into the output register and held until taken before
// the next is read; the largest has tlast set, then the next set may load.
module heap_sorter
  import hsort_pkg::*;
#(
  parameter int unsigned MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  localparam int unsigned TDATA_W   = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input items
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [TDATA_W-1:0] s_axis_tdata_i,   // item_value, zero pad
  input  logic               s_axis_tlast_i,   // last_in
  // result items
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TDATA_W-1:0] m_axis_tdata_o,   // sorted_value, zero pad
  output logic               m_axis_tlast_o,   // final_out
  output logic               m_axis_tuser_o    // overflowed
);

  localparam int unsigned AW  = $clog2(MAX_ITEMS);      // ram address
  localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);  // count 0..MAX_ITEMS
  localparam int unsigned CIW = AW + 2;                 // child index up to 2*MAX

  // sequencer registers
  hsort_state_e            state_q, state_d;
  logic [CW-1:0]           count_q, count_d;   // values held
  logic                    ovf_q, ovf_d;       // a value was dropped
  logic [CW-1:0]           n_q, n_d;           // size of the set being sorted
  logic [CW-1:0]           size_q, size_d;     // heap size for current sift
  logic [AW-1:0]           node_q, node_d;     // sift position
  logic [AW-1:0]           b_q, b_d;           // build index
  logic [AW-1:0]           k_q, k_d;           // heap end, later emit index
  logic                    sorting_q, sorting_d;
  logic [VALUE_BITS-1:0]   val_q, val_d;       // value being sifted down

  // output register
  logic                    m_valid_q, m_valid_d;
  logic [VALUE_BITS-1:0]   m_data_q, m_data_d;
  logic                    m_last_q, m_last_d;

  // ram port
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [VALUE_BITS-1:0]   wdata;
  logic [AW-1:0]           raddr_a, raddr_b;
  logic [VALUE_BITS-1:0]   rdata_a, rdata_b;

  hsort_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  // helper values
  logic            in_acc;
  logic            full;
  logic [CW-1:0]   n_new;
  logic [CW-1:0]   n_new_m1;
  logic [CIW-1:0]  child1, child2, size_ext;
  logic            has_c1, has_c2;
  logic            pick_right;
  logic [VALUE_BITS-1:0] pick_val;
  logic [CIW-1:0]  pick_idx;
  logic            sift_done;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign full     = (count_q == CW'(MAX_ITEMS));
  assign n_new    = full ? count_q : count_q + CW'(1);
  assign n_new_m1 = n_new - CW'(1);

  // children of the current node
  assign child1     = {1'b0, node_q, 1'b1};
  assign child2     = child1 + CIW'(1);
  assign size_ext   = CIW'(size_q);
  assign has_c1     = child1 < size_ext;
  assign has_c2     = child2 < size_ext;
  assign pick_right = has_c2 && ($signed(rdata_a) < $signed(rdata_b));
  assign pick_val   = pick_right ? rdata_b : rdata_a;
  assign pick_idx   = pick_right ? child2 : child1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      sorting_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      sorting_q <= sorting_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload and index registers
  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    size_q   <= size_d;
    node_q   <= node_d;
    b_q      <= b_d;
    k_q      <= k_d;
    val_q    <= val_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    n_d       = n_q;
    size_d    = size_q;
    node_d    = node_q;
    b_d       = b_q;
    k_d       = k_q;
    sorting_d = sorting_q;
    val_d     = val_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    we        = 1'b0;
    waddr     = node_q;
    wdata     = val_q;
    raddr_a   = k_q;
    raddr_b   = k_q;
    sift_done = 1'b0;
    s_axis_tready_o = 1'b0;

    case (state_q)
      ST_LOAD: begin
        s_axis_tready_o = 1'b1;
        if (in_acc) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            we      = 1'b1;
            waddr   = count_q[AW-1:0];
            wdata   = s_axis_tdata_i[VALUE_BITS-1:0];
            count_d = n_new;
          end
          if (s_axis_tlast_i) begin
            n_d       = n_new;
            sorting_d = 1'b0;
            if (n_new < CW'(2)) begin
              k_d     = '0;
              state_d = ST_EMIT_RD;
            end else begin
              // start at (n-1)/2: the last internal node for even n, a leaf for odd n
              b_d     = n_new_m1[AW-1:0] >> 1;
              state_d = ST_BUILD;
            end
          end
        end
      end

      ST_BUILD: begin
        raddr_a = b_q;
        state_d = ST_BUILD_GET;
      end

      ST_BUILD_GET: begin
        val_d   = rdata_a;
        node_d  = b_q;
        size_d  = n_q;
        state_d = ST_SIFT_RD;
      end

      ST_SIFT_RD: begin
        raddr_a = child1[AW-1:0];
        raddr_b = child2[AW-1:0];
        if (has_c1) begin
          state_d = ST_SIFT_CMP;
        end else begin
          we        = 1'b1;
          sift_done = 1'b1;
        end
      end

      ST_SIFT_CMP: begin
        we = 1'b1;
        if ($signed(val_q) < $signed(pick_val)) begin
          // larger child moves up, hole moves down
          wdata   = pick_val;
          node_d  = pick_idx[AW-1:0];
          state_d = ST_SIFT_RD;
        end else begin
          sift_done = 1'b1;
        end
      end

      ST_SWAP_RD: begin
        raddr_a = '0;
        raddr_b = k_q;
        state_d = ST_SWAP_WR;
      end

      ST_SWAP_WR: begin
        // root goes to the end, old end sifts down from the root
        we      = 1'b1;
        waddr   = k_q;
        wdata   = rdata_a;
        val_d   = rdata_b;
        node_d  = '0;
        size_d  = CW'(k_q);
        state_d = ST_SIFT_RD;
      end

      ST_EMIT_RD: begin
        raddr_a = k_q;
        state_d = ST_EMIT_SHOW;
      end

      ST_EMIT_SHOW: begin
        m_valid_d = 1'b1;
        m_data_d  = rdata_a;
        m_last_d  = (CW'(k_q) == n_q - CW'(1));
        state_d   = ST_EMIT_WAIT;
      end

      ST_EMIT_WAIT: begin
        if (m_axis_tready_i) begin
          m_valid_d = 1'b0;
          if (m_last_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            k_d     = k_q + AW'(1);
            raddr_a = k_q + AW'(1);
            state_d = ST_EMIT_SHOW;
          end
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase

    // end of one sift: next build node, next swap, or start emitting
    if (sift_done) begin
      if (!sorting_q) begin
        if (b_q == '0) begin
          sorting_d = 1'b1;
          k_d       = n_q[AW-1:0] - AW'(1);
          state_d   = ST_SWAP_RD;
        end else begin
          b_d     = b_q - AW'(1);
          state_d = ST_BUILD;
        end
      end else begin
        if (k_q == AW'(1)) begin
          k_d     = '0;
          state_d = ST_EMIT_RD;
        end else begin
          k_d     = k_q - AW'(1);
          state_d = ST_SWAP_RD;
        end
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = TDATA_W'(m_data_q);
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = ovf_q;

  // fill count never passes capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ITEMS))
    else $error("item count beyond capacity");

  // a compared node always lies inside the heap
  a_sift_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SIFT_CMP |-> CW'(node_q) < size_q)
    else $error("sift node outside heap");

  // the store is not written while results are being delivered
  a_no_write_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_WAIT || state_q == ST_EMIT_SHOW) |-> !we)
    else $error("store write during emit");

  // the final result carries the last index of the set
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_last_q |-> CW'(k_q) == n_q - CW'(1))
    else $error("final flag on wrong index");

  // taking the final result reopens the input with an empty store
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_axis_tready_i && m_last_q |=> state_q == ST_LOAD && count_q == '0
      && !ovf_q)
    else $error("run did not end cleanly");

endmodule
